// File: design/event_loop_recorder_player_defines.svh
// ----------------------------------------------------------------------------
// event loop recorder/player assertion macros
// shared concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef EVENT_LOOP_RECORDER_PLAYER_DEFINES_SVH
`define EVENT_LOOP_RECORDER_PLAYER_DEFINES_SVH

`ifndef SYNTHESIS
`define ELRP_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("elrp assertion failed");
`define ELRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("elrp assertion failed");
`else
`define ELRP_ASSERT_NOW(lbl, cond)
`define ELRP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/elrp_pkg.sv
// ----------------------------------------------------------------------------
// elrp_pkg
// shared constants and types of the event loop recorder/player
// ----------------------------------------------------------------------------
package elrp_pkg;

    localparam int EVENT_CAPACITY = 32;
    localparam int CNT_W          = $clog2(EVENT_CAPACITY + 1);
    localparam int IDX_W          = (EVENT_CAPACITY > 1) ? $clog2(EVENT_CAPACITY) : 1;

    localparam int TIME_W         = 32;
    localparam int DIV_CNT_W      = $clog2(TIME_W);

    localparam int DRUM_W         = 8;
    localparam int VEL_W          = 16;
    localparam int CMD_W          = 3;

    localparam int IN_DATA_W      = 56;
    localparam int OUT_DATA_W     = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_START_REC = 3'd0,
        CMD_STOP_REC  = 3'd1,
        CMD_ADD_EVENT = 3'd2,
        CMD_TICK      = 3'd3,
        CMD_CLEAR     = 3'd4
    } t_cmd;

    typedef enum logic {
        KIND_EVENT  = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        logic [TIME_W-1:0] offset;
        logic [DRUM_W-1:0] drum;
        logic [VEL_W-1:0]  vel;
    } t_event;

endpackage

// File: design/elrp_mod32.sv
// ----------------------------------------------------------------------------
// elrp_mod32
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module elrp_mod32
    import elrp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [TIME_W-1:0] i_divisor,
    output logic              o_done,
    output logic [TIME_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]    r_rem;
    logic [TIME_W-1:0]    r_dvd;
    logic [TIME_W-1:0]    r_div;

    logic [TIME_W:0]      w_shift;
    logic [TIME_W:0]      w_diff;
    logic [TIME_W-1:0]    n_rem;

    always_comb begin
        w_shift = {r_rem, r_dvd[TIME_W-1]};
        w_diff  = w_shift - {1'b0, r_div};
        // keep the partial remainder when the trial subtract goes negative
        if (w_diff[TIME_W]) begin
            n_rem = w_shift[TIME_W-1:0];
        end else begin
            n_rem = w_diff[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: design/event_loop_recorder_player.sv
// ----------------------------------------------------------------------------
// event_loop_recorder_player
// records timed drum events into a small store and loops them back on ticks
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command per transfer: tuser = cmd (start record, stop
//   record, add event, tick, clear), tdata = sample_time, drum_id, velocity.
//   m_axis returns the results of that command: zero or more triggered events
//   (tuser = 0) followed by one status word (tuser = 1, tlast = 1).
//   one command is worked on at a time; s_axis_tready is low until its status
//   word has been placed in the output register.
//   commands other than a playing tick go through the status state, then their
//   status word is placed in the output register. a playing tick runs the
//   position modulo through a 32-step remainder unit, then walks the store
//   one entry per cycle, unless a firing event waits, via its registered read port.
//   a stalled receiver holds the output register; the walk waits on each
//   firing event until the register is free, nothing is dropped.
//   reset (synchronous, active low) clears flags, count, times and loop
//   length; store contents are only read below the stored count.
// ----------------------------------------------------------------------------
`include "event_loop_recorder_player_defines.svh"

module event_loop_recorder_player
    import elrp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // s_axis_tdata: sample_time[31:0], drum_id[39:32], velocity[55:40]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: cmd[2:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // m_axis_tdata: out_drum[7:0], out_velocity[23:8], is_recording[24],
    //               is_playing[25], loop_length[57:26], zero[63:58]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // m_axis_tuser: kind[0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_CHK  = 5'b01000,
        S_STAT = 5'b10000
    } t_state;

    // control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_rec, n_rec;
    logic              r_play, n_play;
    logic [TIME_W-1:0] r_start, n_start;
    logic [TIME_W-1:0] r_span, n_span;
    logic [TIME_W-1:0] r_prev, n_prev;
    logic [TIME_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0]  r_idx, n_idx;

    // output register
    logic              r_m_valid;
    logic              r_m_kind;
    logic [DRUM_W-1:0] r_m_drum;
    logic [VEL_W-1:0]  r_m_vel;
    logic              r_m_rec;
    logic              r_m_play;
    logic [TIME_W-1:0] r_m_len;
    logic              r_m_last;

    // event store
    t_event            r_mem [EVENT_CAPACITY];
    t_event            r_rd_data;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    t_event            w_wr_data;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;

    // inputs
    logic              w_in_acc;
    t_cmd              w_cmd;
    logic [TIME_W-1:0] w_t;
    logic [DRUM_W-1:0] w_drum;
    logic [VEL_W-1:0]  w_vel;

    logic              w_out_free;
    logic              w_emit_evt;
    logic              w_emit_stat;
    logic              w_fire;
    logic              w_last_idx;
    logic [TIME_W-1:0] w_off;
    logic [TIME_W-1:0] w_add_start;
    logic              w_div_start;
    logic              w_div_done;
    logic [TIME_W-1:0] w_div_rem;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_cmd      = t_cmd'(s_axis_tuser);
    assign w_t        = s_axis_tdata[TIME_W-1:0];
    assign w_drum     = s_axis_tdata[TIME_W+DRUM_W-1:TIME_W];
    assign w_vel      = s_axis_tdata[TIME_W+DRUM_W+VEL_W-1:TIME_W+DRUM_W];
    assign w_out_free = !r_m_valid || m_axis_tready;

    assign w_off      = r_rd_data.offset;
    assign w_last_idx = (CNT_W'(r_idx + 1'b1) == r_count);

    // first event of a take sets the start time, unless it is already set
    assign w_add_start = ((r_start == '0) && (r_count == '0)) ? w_t : r_start;

    assign w_div_start = w_in_acc && (w_cmd == CMD_TICK) && r_play
                         && (r_span != '0) && (r_count != '0);

    always_comb begin
        priority if (r_prev < r_pos) begin
            w_fire = (w_off > r_prev) && (w_off <= r_pos);
        end else if (r_pos < r_prev) begin
            w_fire = (w_off > r_prev) || (w_off <= r_pos);
        end else begin
            w_fire = (w_off == r_pos);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rec       = r_rec;
        n_play      = r_play;
        n_start     = r_start;
        n_span      = r_span;
        n_prev      = r_prev;
        n_pos       = r_pos;
        n_idx       = r_idx;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_count[IDX_W-1:0];
        w_wr_data   = '{offset: w_t - w_add_start, drum: w_drum, vel: w_vel};
        w_rd_en     = 1'b0;
        w_rd_addr   = r_idx[IDX_W-1:0];
        w_emit_evt  = 1'b0;
        w_emit_stat = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_STAT;
                    unique case (w_cmd)
                        CMD_START_REC: begin
                            n_count = '0;
                            n_rec   = 1'b1;
                            n_play  = 1'b0;
                            n_start = '0;
                            n_prev  = '0;
                        end
                        CMD_STOP_REC: begin
                            n_rec  = 1'b0;
                            n_play = (r_count != '0);
                            n_span = (r_start != '0) ? (w_t - r_start) : '0;
                            n_prev = '0;
                        end
                        CMD_ADD_EVENT: begin
                            if (r_rec) begin
                                n_start = w_add_start;
                                if (r_count < CNT_W'(EVENT_CAPACITY)) begin
                                    w_wr_en = 1'b1;
                                    n_count = CNT_W'(r_count + 1'b1);
                                end else begin
                                    // full store: behaves as a stop at this time
                                    n_rec  = 1'b0;
                                    n_play = 1'b1;
                                    n_span = (w_add_start != '0) ?
                                             (w_t - w_add_start) : '0;
                                    n_prev = '0;
                                end
                            end
                        end
                        CMD_TICK: begin
                            if (w_div_start) begin
                                n_state = S_DIV;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_rec   = 1'b0;
                            n_play  = 1'b0;
                            n_span  = '0;
                            n_start = '0;
                            n_prev  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_pos   = w_div_rem;
                    n_idx   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!w_fire || w_out_free) begin
                    w_emit_evt = w_fire;
                    if (w_last_idx) begin
                        n_prev  = r_pos;
                        n_state = S_STAT;
                    end else begin
                        n_idx     = CNT_W'(r_idx + 1'b1);
                        w_rd_en   = 1'b1;
                        w_rd_addr = n_idx[IDX_W-1:0];
                    end
                end
            end
            S_STAT: begin
                if (w_out_free) begin
                    w_emit_stat = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rec     <= 1'b0;
            r_play    <= 1'b0;
            r_start   <= '0;
            r_span    <= '0;
            r_prev    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rec   <= n_rec;
            r_play  <= n_play;
            r_start <= n_start;
            r_span  <= n_span;
            r_prev  <= n_prev;
            if (w_emit_evt || w_emit_stat) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_idx <= n_idx;
        if (w_emit_evt || w_emit_stat) begin
            r_m_kind <= w_emit_stat ? KIND_STATUS : KIND_EVENT;
            r_m_drum <= w_emit_stat ? '0 : r_rd_data.drum;
            r_m_vel  <= w_emit_stat ? '0 : r_rd_data.vel;
            r_m_rec  <= r_rec;
            r_m_play <= r_play;
            r_m_len  <= r_span;
            r_m_last <= w_emit_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    elrp_mod32 u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_t - r_start),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = {{(OUT_DATA_W - 2*TIME_W + 6){1'b0}},
                            r_m_len, r_m_play, r_m_rec, r_m_vel, r_m_drum};

    `ELRP_ASSERT_NOW(a_rec_play_excl, !(r_rec && r_play))
    `ELRP_ASSERT_NOW(a_walk_in_range, (r_state != S_CHK) || (r_idx < r_count))
    `ELRP_ASSERT_NEXT(a_busy_after_acc, w_in_acc, !s_axis_tready)
    `ELRP_ASSERT_NOW(a_last_is_status, !r_m_valid || (r_m_last == r_m_kind))

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the event loop recorder/player: a scripted opening
// covers reset, extremes, the unset start time, the full store and idle ticks,
// then random record/stop/tick sequences run under four handshake phases;
// every result transfer is compared against an in-bench prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import elrp_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 240;
    localparam int SCRIPT_LEN   = 27;

    // codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        t_kind             kind;
        logic [DRUM_W-1:0] drum;
        logic [VEL_W-1:0]  vel;
        logic              rec;
        logic              play;
        logic [TIME_W-1:0] span;
        logic              last;
    } t_loop_result;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] t;
        logic [DRUM_W-1:0] drum;
        logic [VEL_W-1:0]  vel;
        int                reps;
        logic [TIME_W-1:0] t_step;
        bit                typed;
        logic              rec;
        logic              play;
        logic [TIME_W-1:0] span;
    } t_script_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    // model of the loop state
    logic [TIME_W-1:0] lp_offset [EVENT_CAPACITY];
    logic [DRUM_W-1:0] lp_drum   [EVENT_CAPACITY];
    logic [VEL_W-1:0]  lp_vel    [EVENT_CAPACITY];
    int                lp_count = 0;
    logic              lp_rec   = 1'b0;
    logic              lp_play  = 1'b0;
    logic [TIME_W-1:0] lp_start = '0;
    logic [TIME_W-1:0] lp_span  = '0;
    logic [TIME_W-1:0] lp_prev  = '0;

    t_loop_result awaited_results [$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int err_cnt       = 0;
    int cmds_accepted = 0;
    int results_seen  = 0;
    int max_burst     = 0;
    int cycle_cnt     = 0;

    t_script_row opening_script [SCRIPT_LEN] = '{
        // after reset: tick, add while idle, stop with nothing recorded, two spare codes
        '{CMD_TICK,      32'd0,        8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0},
        '{CMD_ADD_EVENT, 32'd5,        8'h12, 16'h3456, 1, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0},
        '{CMD_STOP_REC,  32'd100,      8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0},
        '{CMD_SPARE_LO,  32'h12345678, 8'h5a, 16'ha5a5, 1, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0},
        '{CMD_SPARE_HI,  32'hffffffff, 8'hff, 16'hffff, 1, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0},
        // first event at time zero leaves the start unset
        '{CMD_START_REC, 32'd0,        8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0},
        '{CMD_ADD_EVENT, 32'd0,        8'hff, 16'hffff, 1, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0},
        '{CMD_ADD_EVENT, 32'hffffffff, 8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0},
        '{CMD_STOP_REC,  32'd50,       8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b0, 1'b1, 32'd0},
        '{CMD_TICK,      32'd7,        8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b0, 1'b1, 32'd0},
        '{CMD_CLEAR,     32'd0,        8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0},
        // a 40 sample loop with two events on the downbeat
        '{CMD_START_REC, 32'd0,        8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0},
        '{CMD_ADD_EVENT, 32'd1000,     8'h01, 16'h0100, 1, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0},
        '{CMD_ADD_EVENT, 32'd1010,     8'h02, 16'h0200, 1, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0},
        '{CMD_ADD_EVENT, 32'd1020,     8'h03, 16'h0300, 1, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0},
        '{CMD_ADD_EVENT, 32'd1000,     8'h04, 16'h0400, 1, 32'd0, 1'b1, 1'b1, 1'b0, 32'd0},
        '{CMD_STOP_REC,  32'd1040,     8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b0, 1'b1, 32'd40},
        '{CMD_TICK,      32'd1000,     8'h00, 16'h0000, 1, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{CMD_TICK,      32'd1010,     8'h00, 16'h0000, 1, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{CMD_TICK,      32'd1035,     8'h00, 16'h0000, 1, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{CMD_TICK,      32'd1045,     8'h00, 16'h0000, 1, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{CMD_TICK,      32'd5,        8'h00, 16'h0000, 1, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0},
        // fill the store, the add after that closes the take
        '{CMD_START_REC, 32'd0,        8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b1, 1'b0, 32'd40},
        '{CMD_ADD_EVENT, 32'd200,      8'h40, 16'h8000, 32, 32'd0, 1'b1, 1'b1, 1'b0, 32'd40},
        '{CMD_ADD_EVENT, 32'd300,      8'h77, 16'h7777, 1, 32'd0, 1'b1, 1'b0, 1'b1, 32'd100},
        '{CMD_TICK,      32'd200,      8'h00, 16'h0000, 1, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{CMD_CLEAR,     32'd0,        8'h00, 16'h0000, 1, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0}
    };

    event_loop_recorder_player uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        if (err_cnt < 100) begin
            $display("[%0t] mismatch at result %0d, %s: got %h, expected %h",
                     $realtime, results_seen, what, got, want);
        end
        err_cnt++;
    endtask

    // same effect as a stop command at time t
    function automatic void close_take(input logic [TIME_W-1:0] t);
        lp_rec  = 1'b0;
        lp_span = (lp_start != '0) ? t - lp_start : '0;
        lp_play = (lp_count != 0);
        lp_prev = '0;
    endfunction

    function automatic void predict_loop_outputs(input logic [CMD_W-1:0] cmd,
                                                 input logic [TIME_W-1:0] t,
                                                 input logic [DRUM_W-1:0] drum,
                                                 input logic [VEL_W-1:0] vel);
        logic [TIME_W-1:0] pos;
        logic              fire;
        int                fired;
        fired = 0;
        cmds_accepted++;
        case (cmd)
            CMD_START_REC: begin
                lp_count = 0;
                lp_rec   = 1'b1;
                lp_play  = 1'b0;
                lp_start = '0;
                lp_prev  = '0;
            end
            CMD_STOP_REC: begin
                close_take(t);
            end
            CMD_ADD_EVENT: begin
                if (lp_rec) begin
                    if (lp_start == '0 && lp_count == 0) begin
                        lp_start = t;
                    end
                    if (lp_count < EVENT_CAPACITY) begin
                        lp_offset[lp_count] = t - lp_start;
                        lp_drum[lp_count]   = drum;
                        lp_vel[lp_count]    = vel;
                        lp_count++;
                    end else begin
                        close_take(t);
                    end
                end
            end
            CMD_TICK: begin
                if (lp_play && lp_span != '0 && lp_count != 0) begin
                    pos = (t - lp_start) % lp_span;
                    for (int i = 0; i < lp_count; i++) begin
                        // window (prev, pos], wrapping past the loop end
                        if (lp_prev < pos) begin
                            fire = (lp_offset[i] > lp_prev) && (lp_offset[i] <= pos);
                        end else if (pos < lp_prev) begin
                            fire = (lp_offset[i] > lp_prev) || (lp_offset[i] <= pos);
                        end else begin
                            fire = (lp_offset[i] == pos);
                        end
                        if (fire) begin
                            awaited_results.push_back('{KIND_EVENT, lp_drum[i], lp_vel[i],
                                                        lp_rec, lp_play, lp_span, 1'b0});
                            fired++;
                        end
                    end
                    lp_prev = pos;
                end
            end
            CMD_CLEAR: begin
                lp_count = 0;
                lp_rec   = 1'b0;
                lp_play  = 1'b0;
                lp_span  = '0;
                lp_start = '0;
                lp_prev  = '0;
            end
            default: begin
            end
        endcase
        awaited_results.push_back('{KIND_STATUS, 8'h00, 16'h0000, lp_rec, lp_play,
                                    lp_span, 1'b1});
        if (fired > max_burst) begin
            max_burst = fired;
        end
    endfunction

    // returns at the edge where the command transfer happens
    task automatic transfer_command(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                                    input logic [DRUM_W-1:0] drum,
                                    input logic [VEL_W-1:0] vel);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {vel, drum, t};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                                input logic [DRUM_W-1:0] drum, input logic [VEL_W-1:0] vel);
        predict_loop_outputs(cmd, t, drum, vel);
        transfer_command(cmd, t, drum, vel);
    endtask

    // sender holds off until every awaited result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // mostly well-formed takes with random content, some noise and broken takes
    task automatic play_random_take();
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] tnow;
        logic [TIME_W-1:0] stop_t;
        int                n_ev;
        int                n_tick;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_command(3'($urandom_range(7)), $urandom, 8'($urandom), 16'($urandom));
        end else if (pick < 13) begin
            send_command(CMD_CLEAR, $urandom, 8'($urandom), 16'($urandom));
        end else begin
            base = ($urandom_range(11) == 0) ? '0 : $urandom;
            if ($urandom_range(99) < 80) begin
                n_ev = $urandom_range(1, 6);
            end else if ($urandom_range(99) < 60) begin
                n_ev = $urandom_range(7, 31);
            end else begin
                n_ev = $urandom_range(32, 34);
            end
            send_command(CMD_START_REC, $urandom, 8'($urandom), 16'($urandom));
            tnow = base;
            for (int e = 0; e < n_ev; e++) begin
                send_command(CMD_ADD_EVENT, tnow, 8'($urandom), 16'($urandom));
                tnow += $urandom_range(0, 15);
            end
            stop_t = tnow + $urandom_range(0, 10);
            if ($urandom_range(9) != 0) begin
                send_command(CMD_STOP_REC, stop_t, 8'($urandom), 16'($urandom));
            end
            n_tick = $urandom_range(2, 10);
            tnow   = stop_t;
            for (int k = 0; k < n_tick; k++) begin
                if ($urandom_range(15) == 0) begin
                    tnow = $urandom;
                end else begin
                    tnow += $urandom_range(0, 2 * (stop_t - base) + 4);
                end
                send_command(CMD_TICK, tnow, 8'($urandom), 16'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_loop_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited", m_axis_tdata[31:0], '0);
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", TIME_W'(m_axis_tuser), TIME_W'(want.kind));
                if (m_axis_tdata[7:0] !== want.drum)
                    report_mismatch("drum", TIME_W'(m_axis_tdata[7:0]), TIME_W'(want.drum));
                if (m_axis_tdata[23:8] !== want.vel)
                    report_mismatch("velocity", TIME_W'(m_axis_tdata[23:8]),
                                    TIME_W'(want.vel));
                if (m_axis_tdata[24] !== want.rec)
                    report_mismatch("recording", TIME_W'(m_axis_tdata[24]),
                                    TIME_W'(want.rec));
                if (m_axis_tdata[25] !== want.play)
                    report_mismatch("playing", TIME_W'(m_axis_tdata[25]),
                                    TIME_W'(want.play));
                if (m_axis_tdata[57:26] !== want.span)
                    report_mismatch("loop length", m_axis_tdata[57:26], want.span);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", TIME_W'(m_axis_tlast), TIME_W'(want.last));
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still awaited",
                 cycle_cnt, awaited_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        t_script_row row;
        int          target;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            row = opening_script[r];
            for (int k = 0; k < row.reps; k++) begin
                predict_loop_outputs(row.cmd, row.t + k * row.t_step,
                                     DRUM_W'(row.drum + k), VEL_W'(row.vel ^ k));
                if (row.typed) begin
                    // status is known outright here, use it instead
                    void'(awaited_results.pop_back());
                    awaited_results.push_back('{KIND_STATUS, 8'h00, 16'h0000, row.rec,
                                                row.play, row.span, 1'b1});
                end
                transfer_command(row.cmd, row.t + k * row.t_step,
                                 DRUM_W'(row.drum + k), VEL_W'(row.vel ^ k));
            end
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            target = cmds_accepted + RANDOM_ITEMS / 4;
            while (cmds_accepted < target) begin
                play_random_take();
            end
            drain_results();
        end

        stall_pct = 0;
        repeat (80) @(posedge i_clk);
        $display("%0d commands over four handshake phases, %0d results checked",
                 cmds_accepted, results_seen);
        $display("largest burst of triggered events in one tick: %0d", max_burst);
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: event_loop_recorder_player.f
+incdir+design
design/elrp_pkg.sv
design/elrp_mod32.sv
design/event_loop_recorder_player.sv
tb/sv/tb_top.sv
